[src/qrpm_pkg.sv]
// Shared constants, queue word type and mask functions for the QR module placer.
`default_nettype none
package qrpm_pkg;

  localparam int DefMaxVersion = 40;
  localparam int SideBase      = 17;
  localparam int SideStep      = 4;
  localparam int TimingCol     = 6;
  localparam int CornerSpan    = 8;
  localparam int DefQueueDepth = 4;
  localparam int ResetSide     = SideBase + SideStep;

  localparam logic [1:0] RegVersion = 2'd0;
  localparam logic [1:0] RegMask    = 2'd1;

  localparam logic [2:0] MaskSum2    = 3'd0;
  localparam logic [2:0] MaskRow2    = 3'd1;
  localparam logic [2:0] MaskCol3    = 3'd2;
  localparam logic [2:0] MaskSum3    = 3'd3;
  localparam logic [2:0] MaskBlock   = 3'd4;
  localparam logic [2:0] MaskProd    = 3'd5;
  localparam logic [2:0] MaskProdPar = 3'd6;
  localparam logic [2:0] MaskMixPar  = 3'd7;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic       last;
  } qrpm_entry_t;

  // v / 3 for 8-bit v via reciprocal multiply
  function automatic logic [7:0] div3_8(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd171;
    return {1'b0, p[15:9]};
  endfunction

  function automatic logic [1:0] mod3_8(input logic [7:0] v);
    logic [7:0] t;
    t = v - (div3_8(v) * 8'd3);
    return t[1:0];
  endfunction

  function automatic logic mask_hit(input logic [2:0] pattern, input logic [7:0] r,
                                    input logic [7:0] c);
    logic [1:0] r3;
    logic [1:0] c3;
    logic [1:0] p3;
    logic [2:0] s3;
    logic [7:0] cq;
    logic       pp;
    logic       hit;
    r3 = mod3_8(r);
    c3 = mod3_8(c);
    cq = div3_8(c);
    s3 = {1'b0, r3} + {1'b0, c3};
    if (s3 >= 3'd3) s3 = s3 - 3'd3;
    case ({r3, c3})
      4'b0101: p3 = 2'd1;
      4'b0110: p3 = 2'd2;
      4'b1001: p3 = 2'd2;
      4'b1010: p3 = 2'd1;
      default: p3 = 2'd0;
    endcase
    pp = r[0] & c[0];
    case (pattern)
      MaskSum2:    hit = ~(r[0] ^ c[0]);
      MaskRow2:    hit = ~r[0];
      MaskCol3:    hit = (c3 == 2'd0);
      MaskSum3:    hit = (s3 == 3'd0);
      MaskBlock:   hit = ~(r[1] ^ cq[0]);
      MaskProd:    hit = ~pp && (p3 == 2'd0);
      MaskProdPar: hit = ~(pp ^ p3[0]);
      MaskMixPar:  hit = ~((r[0] ^ c[0]) ^ p3[0]);
      default:     hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage
`default_nettype wire

[src/qrpm_queue.sv]
// Short FIFO of placed module positions between walker and masker.
`default_nettype none
module qrpm_queue import qrpm_pkg::*; #(
  parameter int DEPTH = DefQueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        flush,
  input  wire logic        push,
  input  wire qrpm_entry_t push_entry,
  input  wire logic        pop,
  output qrpm_entry_t      pop_entry,
  output logic             empty,
  output logic             full
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  qrpm_entry_t       mem [DEPTH];
  logic [PtrW-1:0]   head;
  logic [PtrW-1:0]   tail;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign empty     = (count == '0);
  assign full      = (count == CntW'(DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = mem[head];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) tail <= bump(tail);
      if (do_pop)  head <= bump(head);
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[tail] <= push_entry;
  end

endmodule
`default_nettype wire

[src/qrpm_walker.sv]
// Zigzag cursor that walks the symbol and queues free module positions.
`default_nettype none
module qrpm_walker import qrpm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        restart,
  input  wire logic [7:0]  restart_side,
  input  wire logic [7:0]  side,
  input  wire logic        queue_full,
  output logic             push,
  output qrpm_entry_t      push_entry,
  output logic             drained
);

  logic [7:0] cursor_row, cursor_row_next;
  logic [7:0] pair_col, pair_col_next;
  logic       moving_up, moving_up_next;
  logic       left_of_pair, left_of_pair_next;
  logic       done, done_next;
  logic       pend_valid, pend_valid_next;
  logic [7:0] pend_row, pend_row_next;
  logic [7:0] pend_col, pend_col_next;
  logic [7:0] col;
  logic [7:0] far_edge;
  logic [7:0] pc_dec;
  logic       reserved;
  logic       step;
  logic       last;

  assign col      = pair_col - {7'd0, left_of_pair};
  assign far_edge = side - 8'(CornerSpan);
  assign reserved = (col == 8'(TimingCol))
                 || (cursor_row < 8'(CornerSpan) && col < 8'(CornerSpan))
                 || (cursor_row < 8'(CornerSpan) && col >= far_edge)
                 || (cursor_row >= far_edge && col < 8'(CornerSpan));
  assign pc_dec   = pair_col - 8'd2;

  assign drained  = done && !pend_valid;

  always_comb begin
    cursor_row_next   = cursor_row;
    pair_col_next     = pair_col;
    moving_up_next    = moving_up;
    left_of_pair_next = left_of_pair;
    done_next         = done;
    pend_valid_next   = pend_valid;
    pend_row_next     = pend_row;
    pend_col_next     = pend_col;
    push              = 1'b0;
    last              = 1'b0;
    step              = !done && (reserved || !pend_valid || !queue_full);

    if (done && pend_valid && !queue_full) begin
      push            = 1'b1;
      last            = 1'b1;
      pend_valid_next = 1'b0;
    end

    if (step) begin
      if (!reserved) begin
        push            = pend_valid;
        pend_valid_next = 1'b1;
        pend_row_next   = cursor_row;
        pend_col_next   = col;
      end
      if (!left_of_pair) begin
        left_of_pair_next = 1'b1;
      end else begin
        left_of_pair_next = 1'b0;
        if (moving_up && cursor_row != 8'd0) begin
          cursor_row_next = cursor_row - 8'd1;
        end else if (!moving_up && cursor_row != side - 8'd1) begin
          cursor_row_next = cursor_row + 8'd1;
        end else if (pair_col < 8'd2) begin
          done_next = 1'b1;
        end else begin
          pair_col_next  = (pc_dec == 8'(TimingCol)) ? 8'(TimingCol - 1) : pc_dec;
          moving_up_next = !moving_up;
        end
      end
    end
  end

  assign push_entry = '{row: pend_row, col: pend_col, last: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row   <= 8'(ResetSide - 1);
      pair_col     <= 8'(ResetSide - 1);
      moving_up    <= 1'b1;
      left_of_pair <= 1'b0;
      done         <= 1'b0;
      pend_valid   <= 1'b0;
    end else if (restart) begin
      cursor_row   <= restart_side - 8'd1;
      pair_col     <= restart_side - 8'd1;
      moving_up    <= 1'b1;
      left_of_pair <= 1'b0;
      done         <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      cursor_row   <= cursor_row_next;
      pair_col     <= pair_col_next;
      moving_up    <= moving_up_next;
      left_of_pair <= left_of_pair_next;
      done         <= done_next;
      pend_valid   <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_row <= pend_row_next;
    pend_col <= pend_col_next;
  end

  a_row_in_symbol: assert property (@(posedge clk) disable iff (rst)
    !done |-> cursor_row < side)
    else $error("cursor row outside symbol");

  a_col_in_symbol: assert property (@(posedge clk) disable iff (rst)
    !done |-> pair_col < side)
    else $error("cursor column outside symbol");

  a_no_timing_col: assert property (@(posedge clk) disable iff (rst)
    push |-> push_entry.col != 8'(TimingCol))
    else $error("module queued in timing column");

endmodule
`default_nettype wire

[src/qrpm_masker.sv]
// Pairs data bits with queued positions, applies the mask, holds the result word.
`default_nettype none
module qrpm_masker import qrpm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [2:0]  mask,
  input  wire logic        data_valid,
  input  wire logic        data_bit,
  output logic             data_stall,
  input  wire logic        q_empty,
  input  wire qrpm_entry_t q_entry,
  input  wire logic        drained,
  output logic             pop,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [7:0]       module_row,
  output logic [7:0]       module_col,
  output logic             module_value,
  output logic             symbol_full,
  output logic             last_module
);

  logic out_space;
  logic accept;

  assign out_space  = !result_valid || !result_stall;
  assign data_stall = !(out_space && (!q_empty || drained));
  assign accept     = data_valid && !data_stall;
  assign pop        = accept && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!q_empty) begin
        module_row   <= q_entry.row;
        module_col   <= q_entry.col;
        module_value <= data_bit ^ mask_hit(mask, q_entry.row, q_entry.col);
        symbol_full  <= 1'b0;
        last_module  <= q_entry.last;
      end else begin
        module_row   <= 8'd0;
        module_col   <= 8'd0;
        module_value <= 1'b0;
        symbol_full  <= 1'b1;
        last_module  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[src/qr_module_placer_masker_core.sv]
// Top level of the QR zigzag module placer with data masking.
`default_nettype none
// Each data word places one bit at the next free module of the symbol and
// returns its row, column and masked value; once the symbol is full every
// word returns symbol_full with zero fields. A walker steps the zigzag cursor
// one module per cycle unless the queue is full, skipping column 6 and the
// finder corners, and runs ahead into a short queue; the masker takes one
// data word per cycle whenever the queue holds a position and the output is
// not stalled, so steady throughput is one word per cycle and only the
// corner runs (up to 32 reserved modules in a row where a pair turns inside
// a corner) can leave the queue empty and stall data words. A result is
// registered and appears in the cycle after its data word is accepted.
// Writing the version register restarts placement from the bottom-right corner.
module qr_module_placer_masker_core import qrpm_pkg::*; #(
  parameter int MAX_VERSION = DefMaxVersion,
  parameter int QUEUE_DEPTH = DefQueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data,
  input  wire logic        data_valid,
  output logic             data_stall,
  input  wire logic        data_bit,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [7:0]       module_row,
  output logic [7:0]       module_col,
  output logic             module_value,
  output logic             symbol_full,
  output logic             last_module
);

  logic [7:0]  side;
  logic [2:0]  mask;
  logic [5:0]  ver_clamp;
  logic [7:0]  side_new;
  logic        restart;
  logic        push;
  logic        pop;
  logic        q_empty;
  logic        q_full;
  logic        drained;
  qrpm_entry_t push_entry;
  qrpm_entry_t q_entry;

  always_comb begin
    ver_clamp = cfg_data;
    if (ver_clamp == 6'd0) ver_clamp = 6'd1;
    if (ver_clamp > 6'(MAX_VERSION)) ver_clamp = 6'(MAX_VERSION);
  end

  assign side_new = 8'(SideBase) + {ver_clamp, 2'b00};
  assign restart  = cfg_write && (cfg_index == RegVersion);

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= 8'(ResetSide);
      mask <= MaskSum2;
    end else if (cfg_write) begin
      if (cfg_index == RegVersion) side <= side_new;
      if (cfg_index == RegMask)    mask <= cfg_data[2:0];
    end
  end

  qrpm_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .restart_side (side_new),
    .side         (side),
    .queue_full   (q_full),
    .push         (push),
    .push_entry   (push_entry),
    .drained      (drained)
  );

  qrpm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .flush      (restart),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (q_entry),
    .empty      (q_empty),
    .full       (q_full)
  );

  qrpm_masker u_masker (
    .clk          (clk),
    .rst          (rst),
    .mask         (mask),
    .data_valid   (data_valid),
    .data_bit     (data_bit),
    .data_stall   (data_stall),
    .q_empty      (q_empty),
    .q_entry      (q_entry),
    .drained      (drained),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .module_row   (module_row),
    .module_col   (module_col),
    .module_value (module_value),
    .symbol_full  (symbol_full),
    .last_module  (last_module)
  );

endmodule
`default_nettype wire
